@@ hdl/sgrgf_pkg.sv @@
// Shared types, constants and decode helpers for the SGR mouse report glitch filter.
package sgrgf_pkg;

  localparam int unsigned COORD_BITS_DEFAULT = 16;
  localparam logic [15:0] LATENCY_RESET      = 16'd20;

  // operation select carried with every input word
  localparam logic [1:0] FUNC_BYTE     = 2'd0;
  localparam logic [1:0] FUNC_TICK     = 2'd1;
  localparam logic [1:0] FUNC_FETCH    = 2'd2;
  localparam logic [1:0] FUNC_DEADLINE = 2'd3;

  localparam logic [7:0] CHAR_ESC     = 8'd27;
  localparam logic [7:0] CHAR_LBRACK  = 8'd91;
  localparam logic [7:0] CHAR_LT      = 8'd60;
  localparam logic [7:0] CHAR_SEMI    = 8'd59;
  localparam logic [7:0] CHAR_DIGIT0  = 8'd48;
  localparam logic [7:0] CHAR_DIGIT9  = 8'd57;
  localparam logic [7:0] CHAR_PRESS   = 8'd77;   // 'M'
  localparam logic [7:0] CHAR_RELEASE = 8'd109;  // 'm'

  localparam logic [15:0] CODE_LEFT   = 16'h303B;
  localparam logic [15:0] CODE_MIDDLE = 16'h313B;
  localparam logic [15:0] CODE_RIGHT  = 16'h323B;
  localparam logic [15:0] CODE_WHEEL_UP   = 16'h3634;
  localparam logic [15:0] CODE_WHEEL_DOWN = 16'h3635;

  localparam logic [2:0] BTN_LEFT       = 3'd0;
  localparam logic [2:0] BTN_MIDDLE     = 3'd1;
  localparam logic [2:0] BTN_RIGHT      = 3'd2;
  localparam logic [2:0] BTN_WHEEL_UP   = 3'd3;
  localparam logic [2:0] BTN_WHEEL_DOWN = 3'd4;
  localparam logic [2:0] BTN_NONE       = 3'd5;

  localparam logic [2:0] POS_CODE_HI = 3'd3;
  localparam logic [2:0] POS_CODE_LO = 3'd4;
  localparam logic [2:0] POS_MAX     = 3'd7;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [2:0]  button;
    logic        pressed;
    logic [31:0] stamp;
  } slot_t;

  typedef struct packed {
    logic        accepted;
    logic        event_valid;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic        event_pressed;
    logic [2:0]  event_button;
    logic [31:0] wait_ms;
  } result_t;

  function automatic logic [7:0] prefix_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0:    b = CHAR_ESC;
      2'd1:    b = CHAR_LBRACK;
      default: b = CHAR_LT;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] button_of(input logic [15:0] code);
    logic [2:0] btn;
    unique case (code)
      CODE_LEFT:       btn = BTN_LEFT;
      CODE_MIDDLE:     btn = BTN_MIDDLE;
      CODE_RIGHT:      btn = BTN_RIGHT;
      CODE_WHEEL_UP:   btn = BTN_WHEEL_UP;
      CODE_WHEEL_DOWN: btn = BTN_WHEEL_DOWN;
      default:         btn = BTN_NONE;
    endcase
    return btn;
  endfunction

endpackage

@@ hdl/sgr_mouse_report_glitch_filter.sv @@
// SGR mouse report decoder with a two-slot event queue and glitch filter.
//
//  channel | direction | handshake            | words
//  --------+-----------+----------------------+--------------------------------------------
//  input   | in        | in_valid / in_ready  | func, data_byte, last_byte, caller_deadline
//  result  | out       | out_valid / out_ready| accepted, event_*, wait_ms
//  config  | in        | cfg_write            | cfg_data (safety latency, ms)
//
// One input word is decoded in the cycle it is accepted; its result sits in the
// output register from the next cycle on. One word per cycle is sustained while
// out_ready stays high; in_ready drops only while a result waits and out_ready is low.
// Synchronous reset clears the parser, clock, both slots and sets latency to LATENCY_RESET.
module sgr_mouse_report_glitch_filter #(
  parameter int unsigned COORD_BITS = sgrgf_pkg::COORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [31:0] caller_deadline,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        accepted,
  output logic        event_valid,
  output logic [15:0] event_x,
  output logic [15:0] event_y,
  output logic        event_pressed,
  output logic [2:0]  event_button,
  output logic [31:0] wait_ms,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);

  localparam int unsigned ACC_W = COORD_BITS + 4;

  function automatic logic [COORD_BITS-1:0] coord_push(input logic [COORD_BITS-1:0] acc,
                                                       input logic [3:0] digit);
    logic [ACC_W-1:0] v;
    v = (ACC_W'(acc) << 3) + (ACC_W'(acc) << 1) + ACC_W'(digit);
    if (|v[ACC_W-1:COORD_BITS]) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  logic [15:0] latency;
  logic [31:0] now_ms, now_next;
  logic [1:0]  slot_valid, slot_valid_next;
  sgrgf_pkg::slot_t [1:0] slot, slot_next;
  logic [2:0]  byte_position, byte_position_next;
  logic        prefix_ok, prefix_ok_next;
  logic [15:0] code_bytes, code_bytes_next;
  logic [1:0]  separator_count, separator_count_next;
  logic        digits_active, digits_active_next;
  logic [COORD_BITS-1:0] x_acc, x_acc_next;
  logic [COORD_BITS-1:0] y_acc, y_acc_next;
  sgrgf_pkg::result_t res, res_next;

  logic        accept;
  logic [31:0] latency32;
  logic [31:0] age0, age1, fin_age, remain;
  logic        mature0, mature1, young0, young1;
  logic [2:0]  btn;
  logic        act_seen;
  logic        act_pressed;
  logic        is_digit;
  logic        sel1;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign latency32 = {16'd0, latency};

  assign age0    = now_ms - slot[0].stamp;
  assign age1    = now_ms - slot[1].stamp;
  assign mature0 = slot_valid[0] && (age0 >= latency32);
  assign mature1 = slot_valid[1] && (age1 >= latency32);
  assign young0  = slot_valid[0] && (age0 < latency32);
  assign young1  = slot_valid[1] && (age1 < latency32);
  assign is_digit = (data_byte >= sgrgf_pkg::CHAR_DIGIT0) &&
                    (data_byte <= sgrgf_pkg::CHAR_DIGIT9);

  always_comb begin
    now_next             = now_ms;
    slot_valid_next      = slot_valid;
    slot_next            = slot;
    byte_position_next   = byte_position;
    prefix_ok_next       = prefix_ok;
    code_bytes_next      = code_bytes;
    separator_count_next = separator_count;
    digits_active_next   = digits_active;
    x_acc_next           = x_acc;
    y_acc_next           = y_acc;
    res_next             = '0;
    btn                  = sgrgf_pkg::BTN_NONE;
    act_seen             = 1'b0;
    act_pressed          = 1'b0;
    fin_age              = '0;
    remain               = '0;
    sel1                 = 1'b0;

    unique case (func)
      sgrgf_pkg::FUNC_BYTE: begin
        if (prefix_ok) begin
          if (byte_position < sgrgf_pkg::POS_CODE_HI) begin
            if (data_byte != sgrgf_pkg::prefix_byte(byte_position[1:0])) begin
              prefix_ok_next = 1'b0;
            end else if (byte_position == 3'd2) begin
              // prefix complete: age the newest event into the older slot
              if (slot_valid[0]) begin
                slot_valid_next[1] = 1'b1;
                slot_next[1]       = slot[0];
              end
              slot_valid_next[0] = 1'b0;
            end
          end else begin
            if (byte_position == sgrgf_pkg::POS_CODE_HI) begin
              code_bytes_next = {data_byte, 8'h00};
            end else if (byte_position == sgrgf_pkg::POS_CODE_LO) begin
              code_bytes_next[7:0] = data_byte;
            end
            if (data_byte == sgrgf_pkg::CHAR_SEMI) begin
              if (separator_count < 2'd2) begin
                separator_count_next = separator_count + 2'd1;
                digits_active_next   = 1'b1;
              end else begin
                digits_active_next = 1'b0;
              end
            end else if (is_digit) begin
              if (digits_active) begin
                if (separator_count == 2'd1) begin
                  x_acc_next = coord_push(x_acc, data_byte[3:0]);
                end else if (separator_count == 2'd2) begin
                  y_acc_next = coord_push(y_acc, data_byte[3:0]);
                end
              end
            end else begin
              digits_active_next = 1'b0;
            end
          end
          if (byte_position < sgrgf_pkg::POS_MAX) begin
            byte_position_next = byte_position + 3'd1;
          end
        end

        if (last_byte) begin
          if (prefix_ok_next && (byte_position_next >= sgrgf_pkg::POS_CODE_HI)) begin
            if (separator_count_next >= 2'd1) slot_next[0].x = 16'(x_acc_next);
            if (separator_count_next >= 2'd2) slot_next[0].y = 16'(y_acc_next);
            btn = sgrgf_pkg::button_of(code_bytes_next);
            if (btn != sgrgf_pkg::BTN_NONE) slot_next[0].button = btn;
            if (data_byte == sgrgf_pkg::CHAR_PRESS) begin
              act_seen    = 1'b1;
              act_pressed = 1'b1;
            end else if (data_byte == sgrgf_pkg::CHAR_RELEASE) begin
              act_seen = 1'b1;
            end
            if (act_seen) slot_next[0].pressed = act_pressed;
            if (act_seen && (btn != sgrgf_pkg::BTN_NONE)) begin
              res_next.accepted = 1'b1;
              fin_age = now_ms - slot_next[1].stamp;
              if (btn >= sgrgf_pkg::BTN_WHEEL_UP) begin
                // scroll is stamped as already mature
                slot_valid_next[0] = 1'b1;
                slot_next[0].stamp = now_ms - latency32;
              end else if (slot_valid_next[1] && (fin_age < latency32)) begin
                // glitch: second click inside the window cancels both
                slot_valid_next = 2'b00;
              end else begin
                slot_valid_next[0] = 1'b1;
                slot_next[0].stamp = now_ms;
              end
            end
          end
          byte_position_next   = '0;
          prefix_ok_next       = 1'b1;
          code_bytes_next      = '0;
          separator_count_next = '0;
          digits_active_next   = 1'b0;
          x_acc_next           = '0;
          y_acc_next           = '0;
        end
      end

      sgrgf_pkg::FUNC_TICK: begin
        now_next = now_ms + 32'd1;
      end

      sgrgf_pkg::FUNC_FETCH: begin
        if (mature1 || mature0) begin
          sel1 = mature1;
          res_next.event_valid   = 1'b1;
          res_next.event_x       = sel1 ? slot[1].x       : slot[0].x;
          res_next.event_y       = sel1 ? slot[1].y       : slot[0].y;
          res_next.event_pressed = sel1 ? slot[1].pressed : slot[0].pressed;
          res_next.event_button  = sel1 ? slot[1].button  : slot[0].button;
          if (sel1) slot_valid_next[1] = 1'b0;
          else      slot_valid_next[0] = 1'b0;
        end
      end

      sgrgf_pkg::FUNC_DEADLINE: begin
        res_next.wait_ms = caller_deadline;
        if ((latency != 16'd0) && (young1 || young0)) begin
          sel1   = young1;
          remain = latency32 + (sel1 ? slot[1].stamp : slot[0].stamp) - now_ms;
          if (remain < caller_deadline) res_next.wait_ms = remain;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latency         <= sgrgf_pkg::LATENCY_RESET;
      now_ms          <= '0;
      slot_valid      <= '0;
      slot            <= '0;
      byte_position   <= '0;
      prefix_ok       <= 1'b1;
      code_bytes      <= '0;
      separator_count <= '0;
      digits_active   <= 1'b0;
      x_acc           <= '0;
      y_acc           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) latency <= cfg_data;
      if (accept) begin
        now_ms          <= now_next;
        slot_valid      <= slot_valid_next;
        slot            <= slot_next;
        byte_position   <= byte_position_next;
        prefix_ok       <= prefix_ok_next;
        code_bytes      <= code_bytes_next;
        separator_count <= separator_count_next;
        digits_active   <= digits_active_next;
        x_acc           <= x_acc_next;
        y_acc           <= y_acc_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

  assign accepted      = res.accepted;
  assign event_valid   = res.event_valid;
  assign event_x       = res.event_x;
  assign event_y       = res.event_y;
  assign event_pressed = res.event_pressed;
  assign event_button  = res.event_button;
  assign wait_ms       = res.wait_ms;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_fetch_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.event_valid |-> !res.accepted && (res.wait_ms == 32'd0))
    else $error("fetch result mixed with other answers");

  a_older_from_copy: assert property (@(posedge clk) disable iff (rst)
    $rose(slot_valid[1]) |-> $past(slot_valid[0]))
    else $error("older slot filled without a newer event");

endmodule
